@@ design/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and font table of the seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // item actions
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_TIME  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_LOAD  = 2'd3
    } action_t;

    typedef logic [4:0]  code_t;
    typedef logic [6:0]  glyph_t;
    typedef logic [6:0]  time_t;
    typedef logic [15:0] count_t;

    localparam int unsigned NUM_DIGITS = 4;

    localparam code_t  CODE_BLANK  = 5'd16;
    localparam code_t  CODE_DASH   = 5'd17;
    localparam glyph_t GLYPH_OFF   = 7'h7F;
    localparam time_t  TIME_MAX    = 7'd99;
    localparam int unsigned RECIP_MUL   = 205;   // 2048 / 10, exact below 1029
    localparam int unsigned RECIP_SHIFT = 11;

    // active-low font: bits C,G,B,F,A,D,E
    function automatic glyph_t glyph_for(input code_t code);
        glyph_t g;
        case (code)
            5'd0:       g = 7'h02;
            5'd1:       g = 7'h7A;
            5'd2:       g = 7'h09;
            5'd3:       g = 7'h48;
            5'd4:       g = 7'h70;
            5'd5:       g = 7'h44;
            5'd6:       g = 7'h04;
            5'd7:       g = 7'h6A;
            5'd8:       g = 7'h00;
            5'd9:       g = 7'h40;
            5'd10:      g = 7'h20;
            5'd11:      g = 7'h14;
            5'd12:      g = 7'h07;
            5'd13:      g = 7'h18;
            5'd14:      g = 7'h05;
            5'd15:      g = 7'h25;
            CODE_BLANK: g = GLYPH_OFF;
            CODE_DASH:  g = 7'h7D;
            default:    g = GLYPH_OFF;
        endcase
        return g;
    endfunction

    // saturate at 99, then split into tens and ones
    function automatic logic [7:0] split_decimal(input time_t v);
        time_t       n;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [3:0]  ones;
        n        = (v > TIME_MAX) ? TIME_MAX : v;
        prod     = 15'(n) * 15'(RECIP_MUL);
        tens     = prod[RECIP_SHIFT +: 4];
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        ones     = 4'(n - tens_x10);
        return {tens, ones};
    endfunction

endpackage

@@ design/ssd_cmd_if.sv @@
// ----------------------------------------------------------------------------
// ssd_cmd_if
// Command channel of the scan driver: action and its operands.
// ----------------------------------------------------------------------------
interface ssd_cmd_if;
    logic              valid;
    logic              ready;
    ssd_pkg::action_t  action;
    logic [6:0]        minutes;
    logic [6:0]        seconds;
    logic [15:0]       countdown_load;

    modport source (
        output valid, action, minutes, seconds, countdown_load,
        input  ready
    );
    modport sink (
        input  valid, action, minutes, seconds, countdown_load,
        output ready
    );
endinterface

@@ design/ssd_drive_if.sv @@
// ----------------------------------------------------------------------------
// ssd_drive_if
// Result channel of the scan driver: segment and strobe drive, countdown.
// ----------------------------------------------------------------------------
interface ssd_drive_if;
    logic        valid;
    logic        ready;
    logic [7:0]  segment_drive_n;
    logic [3:0]  digit_strobe_n;
    logic [15:0] countdown_left;

    modport source (
        output valid, segment_drive_n, digit_strobe_n, countdown_left,
        input  ready
    );
    modport sink (
        input  valid, segment_drive_n, digit_strobe_n, countdown_left,
        output ready
    );
endinterface

@@ design/seven_segment_scan_driver.sv @@
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Scan driver for a four-digit multiplexed active-low seven-segment display.
// ----------------------------------------------------------------------------
// Takes one command item per clock while drive.ready is high and returns
// its result item from a register in the next cycle; the display state
// registers double as the result register, so a new item is taken in the
// same cycle that the previous result is taken. A tick drives the digit
// under the scan index (strobe, font and point), advances the scan and
// counts the countdown down to zero; show_time writes mm.ss as decimal
// digits with a blank leading minute zero and the point on digit 1; clear
// blanks all digits; load sets the countdown. On non-tick items the segment
// and strobe outputs repeat the drive of the last tick (all off after reset).
module seven_segment_scan_driver (
    input  logic         clk,
    input  logic         rst_n,
    ssd_cmd_if.sink      cmd,
    ssd_drive_if.source  drive
);

    ssd_pkg::code_t   digit_reg [ssd_pkg::NUM_DIGITS];
    ssd_pkg::code_t   digit_next [ssd_pkg::NUM_DIGITS];
    logic [1:0]       point_reg, point_next;
    logic [1:0]       scan_reg, scan_next;
    ssd_pkg::count_t  count_reg, count_next;
    logic [7:0]       seg_reg, seg_next;
    logic [3:0]       strobe_reg, strobe_next;
    logic             valid_reg, valid_next;

    logic             accept;
    ssd_pkg::code_t   cur_code;
    logic [7:0]       min_split;
    logic [7:0]       sec_split;

    // take a new item whenever the result slot is free or being emptied
    assign cmd.ready = !valid_reg || drive.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign cur_code  = digit_reg[scan_reg];
    assign min_split = ssd_pkg::split_decimal(cmd.minutes);
    assign sec_split = ssd_pkg::split_decimal(cmd.seconds);

    // next-state logic per action
    always_comb
    begin
        digit_next  = digit_reg;
        point_next  = point_reg;
        scan_next   = scan_reg;
        count_next  = count_reg;
        seg_next    = seg_reg;
        strobe_next = strobe_reg;
        valid_next  = valid_reg && !drive.ready;
        if (accept)
        begin
            valid_next = 1'b1;
            case (cmd.action)
                ssd_pkg::ACT_TICK:
                begin
                    seg_next    = {(point_reg != scan_reg), ssd_pkg::glyph_for(cur_code)};
                    strobe_next = ~(4'b0001 << scan_reg);
                    scan_next   = scan_reg + 2'd1;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 16'd1;
                    end
                end
                ssd_pkg::ACT_TIME:
                begin
                    digit_next[0] = (min_split[7:4] == 4'd0) ? ssd_pkg::CODE_BLANK
                                                             : {1'b0, min_split[7:4]};
                    digit_next[1] = {1'b0, min_split[3:0]};
                    digit_next[2] = {1'b0, sec_split[7:4]};
                    digit_next[3] = {1'b0, sec_split[3:0]};
                    point_next    = 2'd1;
                end
                ssd_pkg::ACT_CLEAR:
                begin
                    for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++)
                    begin
                        digit_next[i] = ssd_pkg::CODE_BLANK;
                    end
                end
                default:
                begin
                    count_next = cmd.countdown_load;
                end
            endcase
        end
    end

    // display state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++)
            begin
                digit_reg[i] <= '0;
            end
            point_reg  <= '0;
            scan_reg   <= '0;
            count_reg  <= '0;
            seg_reg    <= '1;
            strobe_reg <= '1;
            valid_reg  <= 1'b0;
        end
        else
        begin
            digit_reg  <= digit_next;
            point_reg  <= point_next;
            scan_reg   <= scan_next;
            count_reg  <= count_next;
            seg_reg    <= seg_next;
            strobe_reg <= strobe_next;
            valid_reg  <= valid_next;
        end
    end

    assign drive.valid           = valid_reg;
    assign drive.segment_drive_n = seg_reg;
    assign drive.digit_strobe_n  = strobe_reg;
    assign drive.countdown_left  = count_reg;

    // a tick strobes exactly one digit
    a_tick_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.action == ssd_pkg::ACT_TICK |=> $countones(strobe_reg) == 3)
        else $error("tick did not strobe exactly one digit");

    // a held result keeps its countdown
    a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !drive.ready |=> $stable(count_reg))
        else $error("countdown changed while result stalled");

    // non-tick items leave the display drive alone
    a_non_tick_drive: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.action != ssd_pkg::ACT_TICK |=> $stable(seg_reg) && $stable(strobe_reg))
        else $error("display drive changed on a non-tick item");

    // a tick counts a nonzero countdown down by one
    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.action == ssd_pkg::ACT_TICK && count_reg != '0
        |=> count_reg == $past(count_reg) - 16'd1)
        else $error("countdown did not decrement on tick");

endmodule
